>>> design/frt_pkg.sv
// ----------------------------------------------------------------------------
// fragment reassembly table package
// shared types and constants for the reassembly table, its checker and testbench
// ----------------------------------------------------------------------------
package frt_pkg;

  localparam int unsigned SlotsDef      = 4;
  localparam int unsigned MaxFragsDef   = 16;
  localparam int unsigned ChunkBytesDef = 256;

  localparam logic [1:0] OpHeader = 2'd0;
  localparam logic [1:0] OpByte   = 2'd1;
  localparam logic [1:0] OpRead   = 2'd2;
  localparam logic [1:0] OpNone   = 2'd3;

  localparam logic [2:0] KindPlainHdr  = 3'd0;
  localparam logic [2:0] KindPlainByte = 3'd1;
  localparam logic [2:0] KindStored    = 3'd2;
  localparam logic [2:0] KindComplete  = 3'd3;
  localparam logic [2:0] KindReject    = 3'd4;
  localparam logic [2:0] KindRead      = 3'd5;

  typedef struct packed {
    logic [1:0]  op;
    logic        fragmented;
    logic [31:0] session_no;
    logic [31:0] request_no;
    logic [31:0] msg_seq;
    logic [3:0]  msg_type;
    logic [4:0]  frag_index;
    logic [5:0]  frag_count;
    logic [11:0] payload_len;
    logic [7:0]  data;
    logic [1:0]  read_slot;
    logic [11:0] read_offset;
  } frt_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_res;
    logic        last;
    logic [1:0]  slot;
    logic [12:0] length;
    logic [3:0]  out_type;
    logic [31:0] out_session;
    logic [31:0] out_request;
    logic [31:0] out_seq;
  } frt_out_t;

endpackage

>>> design/frt_ram.sv
// ----------------------------------------------------------------------------
// frt ram
// single port generic ram with registered read
// ----------------------------------------------------------------------------
module frt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

>>> design/fragment_reassembly_table.sv
// ----------------------------------------------------------------------------
// fragment reassembly table
// files fragments of decoded frames into reassembly slots, reads bodies back
// ----------------------------------------------------------------------------
// an item is transferred on start while busy is low. at most one result
// follows, shown for exactly one cycle with valid_o high; busy is already low
// in that cycle, so the next item can be transferred at the edge ending it.
// the receiver cannot stall. steps each kind of item takes before busy is low
// again, the result (if any) being shown after the last of them:
//   plain header, header rejected on its fields, ignored op: busy stays low
//   payload byte: one sequencer step; the last byte of a fragment takes a
//   commit step as well, which commits the chunk
//   read: fragment length ram and body ram are read one after the other
//   through their registered ports
//   fragment header: a single slot comparator steps over the slots, one a
//   cycle, stopping at a match, then decide and duplicate check, and a
//   commit step for an empty fragment that commits at once
// reset frees every slot and closes any open frame; the slot tables and the
// rams are not cleared, a slot's mask is cleared when it is initialised.
// ----------------------------------------------------------------------------
module fragment_reassembly_table #(
  parameter int unsigned SLOTS       = frt_pkg::SlotsDef,
  parameter int unsigned MAX_FRAGS   = frt_pkg::MaxFragsDef,
  parameter int unsigned CHUNK_BYTES = frt_pkg::ChunkBytesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  frt_pkg::frt_in_t item_i,
  output logic             busy,
  output logic             valid_o,
  output frt_pkg::frt_out_t result_o
);
  import frt_pkg::*;

  localparam int unsigned SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned FW  = (MAX_FRAGS > 1) ? $clog2(MAX_FRAGS) : 1;
  localparam int unsigned CW  = $clog2(CHUNK_BYTES);
  localparam int unsigned LW  = CW + 1;
  localparam int unsigned FLD = SLOTS * MAX_FRAGS;
  localparam int unsigned BD  = FLD * CHUNK_BYTES;
  localparam int unsigned FAW = $clog2(FLD) > 0 ? $clog2(FLD) : 1;
  localparam int unsigned BAW = $clog2(BD);
  localparam int unsigned CNW = SW + 1;

  typedef enum logic [3:0] {
    StIdle, StScan, StDecide, StHdrDup, StByte, StCommit, StRd1, StRd2, StRd3
  } state_e;

  state_e state_q;
  frt_in_t in_q;
  frt_out_t res_q;
  logic valid_q;

  logic [SLOTS-1:0] sbusy_q;
  logic [31:0] ses_q [SLOTS];
  logic [31:0] req_q [SLOTS];
  logic [31:0] seq_q [SLOTS];
  logic [3:0]  typ_q [SLOTS];
  logic [5:0]  cnt_q [SLOTS];
  logic [5:0]  rcv_q [SLOTS];
  logic [MAX_FRAGS-1:0] mask_q [SLOTS];
  logic [12:0] nze_q [SLOTS];

  // frame context
  logic [1:0]  mode_q;  // 0 idle 1 plain 2 store
  logic [11:0] left_q;
  logic [SW-1:0] cslot_q;
  logic [FW-1:0] cidx_q;
  logic [11:0] pos_q;
  logic [LW-1:0] end_q;

  // scan state
  logic [CNW-1:0] scan_q;
  logic found_q, free_ok_q, vic_ok_q;
  logic [SW-1:0] match_q, free_q, vic_q;

  // rams
  logic fl_we, bd_we;
  logic [FAW-1:0] fl_addr;
  logic [BAW-1:0] bd_addr;
  logic [LW-1:0] fl_wdata, fl_rdata;
  logic [7:0] bd_rdata;
  logic rd_ok_q;
  logic [CW-1:0] rd_w_q;

  frt_ram #(.Width(LW), .Depth(FLD)) u_flen (
    .clk_i, .we_i(fl_we), .addr_i(fl_addr), .wdata_i(fl_wdata), .rdata_o(fl_rdata)
  );
  frt_ram #(.Width(8), .Depth(BD)) u_body (
    .clk_i, .we_i(bd_we), .addr_i(bd_addr), .wdata_i(in_q.data), .rdata_o(bd_rdata)
  );

  logic [11:0] ch_full;
  logic [SW-1:0] rs;
  logic [FW-1:0] rch;
  logic rd_ok;
  logic [SW-1:0] scan_s;
  logic [SW-1:0] pick;
  logic [FW-1:0] hidx;
  always_comb begin
    ch_full = in_q.read_offset >> CW;
    rs  = SW'(in_q.read_slot);
    rch = FW'(ch_full);
    rd_ok = (32'(in_q.read_slot) < SLOTS) && (32'(ch_full) < MAX_FRAGS)
            && mask_q[rs][rch];
    scan_s = SW'(scan_q);
    pick = found_q ? match_q : (free_ok_q ? free_q : (vic_ok_q ? vic_q : '0));
    hidx = FW'(in_q.frag_index);
  end

  always_comb begin
    fl_we = 1'b0;
    bd_we = 1'b0;
    fl_wdata = 12'(pos_q) > 12'(CHUNK_BYTES) ? LW'(CHUNK_BYTES) : LW'(pos_q);
    fl_addr = FAW'(32'(cslot_q) * MAX_FRAGS + 32'(cidx_q));
    bd_addr = BAW'((32'(cslot_q) * MAX_FRAGS + 32'(cidx_q)) * CHUNK_BYTES
                   + 32'(pos_q[CW-1:0]));
    case (state_q)
      StByte: bd_we = (mode_q == 2'd2) && (32'(pos_q) < CHUNK_BYTES);
      StCommit: fl_we = 1'b1;
      StRd1: fl_addr = FAW'(32'(rs) * MAX_FRAGS + 32'(rch));
      StRd2: bd_addr = BAW'((32'(rs) * MAX_FRAGS + 32'(rch)) * CHUNK_BYTES
                            + 32'(rd_w_q));
      default: ;
    endcase
  end

  assign busy     = (state_q != StIdle);
  assign valid_o  = valid_q;
  assign result_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [12:0] reach;
    logic [5:0] nr;
    frt_out_t res_d;
    logic valid_d;
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= 1'b0;
      res_q   <= '0;
      sbusy_q <= '0;
      mode_q  <= 2'd0;
      left_q  <= '0;
      scan_q  <= '0;
      found_q <= 1'b0;
      free_ok_q <= 1'b0;
      vic_ok_q <= 1'b0;
    end else begin
      valid_d = 1'b0;
      res_d   = '0;
      case (state_q)
        StIdle: begin
          if (start) begin
            in_q <= item_i;
            if (item_i.op == OpRead) begin
              state_q <= StRd1;
            end else if (item_i.op == OpByte) begin
              state_q <= StByte;
            end else if (item_i.op == OpHeader) begin
              if (!item_i.fragmented) begin
                mode_q <= (item_i.payload_len != '0) ? 2'd1 : 2'd0;
                left_q <= item_i.payload_len;
                valid_d = 1'b1;
                res_d.kind = KindPlainHdr;
                res_d.last = (item_i.payload_len == '0);
                res_d.length = 13'(item_i.payload_len);
                res_d.out_type = item_i.msg_type;
                res_d.out_session = item_i.session_no;
                res_d.out_request = item_i.request_no;
              end else begin
                mode_q <= 2'd0;
                left_q <= '0;
                if (32'(item_i.frag_count) > MAX_FRAGS ||
                    6'(item_i.frag_index) >= item_i.frag_count) begin
                  valid_d = 1'b1;
                  res_d.kind = KindReject;
                end else begin
                  scan_q <= '0;
                  found_q <= 1'b0;
                  free_ok_q <= 1'b0;
                  vic_ok_q <= 1'b0;
                  state_q <= StScan;
                end
              end
            end
          end
        end
        StScan: begin
          // one slot compared per cycle
          if (sbusy_q[scan_s] && ses_q[scan_s] == in_q.session_no &&
              req_q[scan_s] == in_q.request_no && seq_q[scan_s] == in_q.msg_seq &&
              cnt_q[scan_s] == in_q.frag_count) begin
            found_q <= 1'b1;
            match_q <= scan_s;
            state_q <= StDecide;
          end else begin
            if (!sbusy_q[scan_s]) begin
              if (!free_ok_q) begin
                free_ok_q <= 1'b1;
                free_q <= scan_s;
              end
            end else if (!vic_ok_q || rcv_q[scan_s] < rcv_q[vic_q]) begin
              vic_ok_q <= 1'b1;
              vic_q <= scan_s;
            end
            if (32'(scan_q) == SLOTS - 1) state_q <= StDecide;
            scan_q <= scan_q + 1'b1;
          end
        end
        StDecide: begin
          match_q <= pick;
          if (!found_q) begin
            sbusy_q[pick] <= 1'b1;
            ses_q[pick] <= in_q.session_no;
            req_q[pick] <= in_q.request_no;
            seq_q[pick] <= in_q.msg_seq;
            typ_q[pick] <= in_q.msg_type;
            cnt_q[pick] <= in_q.frag_count;
            rcv_q[pick] <= '0;
            mask_q[pick] <= '0;
            nze_q[pick] <= '0;
          end
          state_q <= StHdrDup;
        end
        StHdrDup: begin
          if (mask_q[match_q][hidx]) begin
            valid_d = 1'b1;
            res_d.kind = KindStored;
            res_d.slot = 2'(match_q);
            state_q <= StIdle;
          end else if (32'(in_q.payload_len) > CHUNK_BYTES) begin
            sbusy_q[match_q] <= 1'b0;
            valid_d = 1'b1;
            res_d.kind = KindReject;
            state_q <= StIdle;
          end else begin
            cslot_q <= match_q;
            cidx_q <= hidx;
            pos_q <= '0;
            end_q <= '0;
            if (in_q.payload_len == '0) begin
              state_q <= StCommit;
            end else begin
              mode_q <= 2'd2;
              left_q <= in_q.payload_len;
              state_q <= StIdle;
            end
          end
        end
        StByte: begin
          if (mode_q == 2'd2 && left_q == 12'd1) state_q <= StCommit;
          else state_q <= StIdle;
          if (mode_q == 2'd1) begin
            left_q <= left_q - 1'b1;
            if (left_q == 12'd1) mode_q <= 2'd0;
            valid_d = 1'b1;
            res_d.kind = KindPlainByte;
            res_d.data_res = in_q.data;
            res_d.last = (left_q == 12'd1);
          end else if (mode_q == 2'd2) begin
            if (32'(pos_q) < CHUNK_BYTES && in_q.data != 8'd0) begin
              end_q <= LW'(pos_q) + 1'b1;
            end
            pos_q <= pos_q + 1'b1;
            left_q <= left_q - 1'b1;
            if (left_q == 12'd1) mode_q <= 2'd0;
          end
        end
        StCommit: begin
          state_q <= StIdle;
          mask_q[cslot_q][cidx_q] <= 1'b1;
          nr = rcv_q[cslot_q] + 1'b1;
          rcv_q[cslot_q] <= nr;
          reach = 13'(32'(cidx_q) * CHUNK_BYTES + 32'(end_q));
          if (end_q != '0 && reach > nze_q[cslot_q]) nze_q[cslot_q] <= reach;
          else reach = nze_q[cslot_q];
          valid_d = 1'b1;
          res_d.slot = 2'(cslot_q);
          if (nr != cnt_q[cslot_q]) begin
            res_d.kind = KindStored;
          end else begin
            sbusy_q[cslot_q] <= 1'b0;
            res_d.kind = KindComplete;
            res_d.length = reach;
            res_d.out_type = typ_q[cslot_q];
            res_d.out_session = ses_q[cslot_q];
            res_d.out_request = req_q[cslot_q];
            res_d.out_seq = seq_q[cslot_q];
          end
        end
        StRd1: begin
          rd_ok_q <= rd_ok;
          rd_w_q <= CW'(in_q.read_offset);
          state_q <= StRd2;
        end
        StRd2: begin
          rd_ok_q <= rd_ok_q && (LW'(rd_w_q) < fl_rdata);
          state_q <= StRd3;
        end
        StRd3: begin
          valid_d = 1'b1;
          res_d.kind = KindRead;
          res_d.data_res = rd_ok_q ? bd_rdata : 8'd0;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
      valid_q <= valid_d;
      res_q   <= res_d;
    end
  end

`ifndef SYNTH
  a_start_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.op != OpNone) |=> (busy || valid_o))
    else $error("item dropped");
  a_plain_no_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == 2'd1) |-> !bd_we) else $error("plain byte written");
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy) else $error("result while busy");
`endif
endmodule

>>> verif/frt_checker.sv
// ----------------------------------------------------------------------------
// fragment reassembly table checker
// watches item and result transfers, predicts every result and compares
// ----------------------------------------------------------------------------
module frt_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             busy,
  input  frt_pkg::frt_in_t item_i,
  input  logic             valid_o,
  input  frt_pkg::frt_out_t result_o,
  output int               errors_o,
  output int               pending_o,
  output int               checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import frt_pkg::*;

  localparam int NSlot  = 4;
  localparam int NFrag  = 16;
  localparam int NChunk = 256;
  localparam int QDepth = 16;

  typedef enum logic [1:0] {CtxIdle, CtxPlain, CtxStore} ctx_e;

  frt_out_t   exp_mem[QDepth];
  logic [3:0] wr_ptr = '0;
  logic [3:0] rd_ptr = '0;
  int         fill = 0;
  int         n_err = 0;
  int         n_chk = 0;
  logic       sl_busy[NSlot];
  logic [31:0] sl_ses[NSlot], sl_req[NSlot], sl_seq[NSlot], sl_mask[NSlot];
  logic [3:0] sl_type[NSlot];
  logic [5:0] sl_cnt[NSlot], sl_rcv[NSlot];
  int         sl_end[NSlot];
  int         frag_len[NSlot*NFrag];
  logic [7:0] body[NSlot*NFrag*NChunk];
  ctx_e       ctx;
  int         ctx_left, ctx_slot, ctx_idx, ctx_pos, ctx_end;

  assign pending_o = fill;
  assign errors_o  = n_err;
  assign checked_o = n_chk;

  task automatic flag(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h, want %0h", what, got, want);
    n_err++;
  endtask

  task automatic queue_result(input frt_out_t r);
    exp_mem[wr_ptr] = r;
    wr_ptr = wr_ptr + 4'd1;
    fill++;
  endtask

  function automatic frt_out_t mk(input logic [2:0] k);
    frt_out_t r;
    r = '0;
    r.kind = k;
    return r;
  endfunction

  task automatic commit_frag(input int s, input int idx, input int len, input int nz);
    frt_out_t r;
    frag_len[s*NFrag+idx] = len;
    sl_mask[s][idx] = 1'b1;
    sl_rcv[s] = sl_rcv[s] + 6'd1;
    if (nz > 0 && idx*NChunk + nz > sl_end[s]) sl_end[s] = idx*NChunk + nz;
    if (sl_rcv[s] != sl_cnt[s]) begin
      r = mk(KindStored);
      r.slot = s[1:0];
    end else begin
      sl_busy[s] = 1'b0;
      r = mk(KindComplete);
      r.slot = s[1:0];
      r.length = sl_end[s][12:0];
      r.out_type = sl_type[s];
      r.out_session = sl_ses[s];
      r.out_request = sl_req[s];
      r.out_seq = sl_seq[s];
    end
    queue_result(r);
  endtask

  task automatic predict(input frt_in_t it);
    frt_out_t r;
    int ch, w, pick, fr, vic;
    logic found;
    case (it.op)
      OpRead: begin
        r = mk(KindRead);
        ch = int'(it.read_offset) / NChunk;
        w = int'(it.read_offset) % NChunk;
        if (sl_mask[it.read_slot][ch] && w < frag_len[int'(it.read_slot)*NFrag+ch])
          r.data_res = body[(int'(it.read_slot)*NFrag+ch)*NChunk + w];
        queue_result(r);
      end
      OpByte: begin
        if (ctx == CtxPlain) begin
          ctx_left--;
          if (ctx_left == 0) ctx = CtxIdle;
          r = mk(KindPlainByte);
          r.data_res = it.data;
          r.last = (ctx_left == 0);
          queue_result(r);
        end else if (ctx == CtxStore) begin
          if (ctx_pos < NChunk) begin
            body[(ctx_slot*NFrag+ctx_idx)*NChunk + ctx_pos] = it.data;
            if (it.data != 8'd0) ctx_end = ctx_pos + 1;
          end
          ctx_pos++;
          ctx_left--;
          if (ctx_left == 0) begin
            ctx = CtxIdle;
            commit_frag(ctx_slot, ctx_idx, ctx_pos, ctx_end);
          end
        end
      end
      OpHeader: begin
        ctx = CtxIdle;
        ctx_left = 0;
        if (!it.fragmented) begin
          if (it.payload_len > 12'd0) begin
            ctx = CtxPlain;
            ctx_left = int'(it.payload_len);
          end
          r = mk(KindPlainHdr);
          r.last = (it.payload_len == 12'd0);
          r.length = {1'b0, it.payload_len};
          r.out_type = it.msg_type;
          r.out_session = it.session_no;
          r.out_request = it.request_no;
          queue_result(r);
        end else if (int'(it.frag_count) > NFrag ||
                     int'(it.frag_index) >= int'(it.frag_count)) begin
          queue_result(mk(KindReject));
        end else begin
          found = 1'b0;
          pick = NSlot; fr = NSlot; vic = NSlot;
          for (int s = 0; s < NSlot && !found; s++) begin
            if (sl_busy[s] && sl_ses[s] == it.session_no && sl_req[s] == it.request_no &&
                sl_seq[s] == it.msg_seq && sl_cnt[s] == it.frag_count) begin
              pick = s;
              found = 1'b1;
            end else if (!sl_busy[s]) begin
              if (fr == NSlot) fr = s;
            end else if (vic == NSlot || sl_rcv[s] < sl_rcv[vic]) begin
              vic = s;
            end
          end
          if (!found) begin
            pick = (fr != NSlot) ? fr : vic;
            sl_busy[pick] = 1'b1;
            sl_ses[pick] = it.session_no;
            sl_req[pick] = it.request_no;
            sl_seq[pick] = it.msg_seq;
            sl_type[pick] = it.msg_type;
            sl_cnt[pick] = it.frag_count;
            sl_rcv[pick] = '0;
            sl_mask[pick] = '0;
            sl_end[pick] = 0;
          end
          if (sl_mask[pick][it.frag_index]) begin
            r = mk(KindStored);
            r.slot = pick[1:0];
            queue_result(r);
          end else if (int'(it.payload_len) > NChunk) begin
            sl_busy[pick] = 1'b0;
            queue_result(mk(KindReject));
          end else if (it.payload_len == 12'd0) begin
            commit_frag(pick, int'(it.frag_index), 0, 0);
          end else begin
            ctx = CtxStore;
            ctx_left = int'(it.payload_len);
            ctx_slot = pick;
            ctx_idx = int'(it.frag_index);
            ctx_pos = 0;
            ctx_end = 0;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic compare(input frt_out_t got);
    frt_out_t want;
    if (fill == 0) begin
      flag("unexpected result kind", 32'(got.kind), 32'd0);
      return;
    end
    want = exp_mem[rd_ptr];
    rd_ptr = rd_ptr + 4'd1;
    fill--;
    n_chk++;
    if (got.kind != want.kind) flag("kind", 32'(got.kind), 32'(want.kind));
    if (got.data_res != want.data_res)
      flag("data_res", 32'(got.data_res), 32'(want.data_res));
    if (got.last != want.last) flag("last", 32'(got.last), 32'(want.last));
    if (got.slot != want.slot) flag("slot", 32'(got.slot), 32'(want.slot));
    if (got.length != want.length) flag("length", 32'(got.length), 32'(want.length));
    if (got.out_type != want.out_type)
      flag("out_type", 32'(got.out_type), 32'(want.out_type));
    if (got.out_session != want.out_session)
      flag("out_session", got.out_session, want.out_session);
    if (got.out_request != want.out_request)
      flag("out_request", got.out_request, want.out_request);
    if (got.out_seq != want.out_seq) flag("out_seq", got.out_seq, want.out_seq);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NSlot; s++) begin
        sl_busy[s] = 1'b0;
        sl_mask[s] = '0;
      end
      ctx = CtxIdle;
      ctx_left = 0;
    end else begin
      // older result first, then the transfer taken at this edge
      if (valid_o) compare(result_o);
      if (start && !busy) predict(item_i);
    end
  end
endmodule

>>> verif/tb_fragment_reassembly_table.sv
// ----------------------------------------------------------------------------
// fragment reassembly table testbench
// directed and random frame, fragment and read traffic with random gaps
// ----------------------------------------------------------------------------
module tb_fragment_reassembly_table;
  timeunit 1ns;
  timeprecision 1ps;
  import frt_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int ItemTarget = 1700;
  localparam int PoolSize   = 6;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  frt_in_t  item_i = '0;
  logic     busy, valid_o;
  frt_out_t result_o;
  int       errors, pending, checked;
  int       cycles = 0;
  int       sent = 0;

  logic [31:0] pool_ses[PoolSize], pool_req[PoolSize], pool_seq[PoolSize];
  logic [5:0]  pool_cnt[PoolSize];
  logic [3:0]  pool_type[PoolSize];

  always #5 clk_i = ~clk_i;

  fragment_reassembly_table uut (
    .clk_i, .rst_ni, .start, .item_i, .busy, .valid_o, .result_o
  );

  frt_checker chk (
    .clk_i, .rst_ni, .start, .busy, .item_i, .valid_o, .result_o,
    .errors_o(errors), .pending_o(pending), .checked_o(checked)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL fragment_reassembly_table");
      $finish;
    end
  end

  task automatic send_item(input frt_in_t it);
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 9) < 3) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    item_i <= it;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    sent++;
  endtask

  function automatic frt_in_t hdr(input logic frag, input logic [31:0] ses,
                                  input logic [31:0] req, input logic [31:0] seq,
                                  input logic [3:0] typ, input logic [4:0] idx,
                                  input logic [5:0] cnt, input logic [11:0] len);
    frt_in_t it;
    it = '0;
    it.op = OpHeader;
    it.fragmented = frag;
    it.session_no = ses;
    it.request_no = req;
    it.msg_seq = seq;
    it.msg_type = typ;
    it.frag_index = idx;
    it.frag_count = cnt;
    it.payload_len = len;
    return it;
  endfunction

  task automatic send_bytes(input int n, input int zero_pct);
    frt_in_t it;
    for (int i = 0; i < n; i++) begin
      it = '0;
      it.op = OpByte;
      it.data = ($urandom_range(0, 99) < zero_pct) ? 8'd0 : 8'($urandom_range(1, 255));
      send_item(it);
    end
  endtask

  task automatic send_read(input logic [1:0] s, input logic [11:0] off);
    frt_in_t it;
    it = '0;
    it.op = OpRead;
    it.read_slot = s;
    it.read_offset = off;
    send_item(it);
  endtask

  task automatic renew_pool(input int k);
    pool_ses[k] = $urandom;
    pool_req[k] = $urandom;
    pool_seq[k] = $urandom;
    pool_type[k] = 4'($urandom_range(0, 13));
    pool_cnt[k] = ($urandom_range(0, 9) == 0) ? 6'd16 : 6'($urandom_range(1, 4));
  endtask

  task automatic random_traffic();
    frt_in_t it;
    int r, k, len, idx;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      k = $urandom_range(0, PoolSize - 1);
      if ($urandom_range(0, 19) == 0) renew_pool(k);
      idx = $urandom_range(0, pool_cnt[k] - 1);
      if ($urandom_range(0, 29) == 0) idx = $urandom_range(0, 31);
      len = $urandom_range(0, 6);
      if ($urandom_range(0, 19) == 0) len = $urandom_range(0, 256);
      if ($urandom_range(0, 49) == 0) len = $urandom_range(257, 4095);
      send_item(hdr(1'b1, pool_ses[k], pool_req[k], pool_seq[k], pool_type[k],
                    5'(idx), pool_cnt[k], 12'(len)));
      if (len > 256) send_bytes(3, 30);
      else if ($urandom_range(0, 19) == 0 && len > 1) send_bytes($urandom_range(1, len - 1), 30);
      else send_bytes(len, 30);
    end else if (r < 70) begin
      len = $urandom_range(0, 5);
      send_item(hdr(1'b0, $urandom, $urandom, $urandom, 4'($urandom_range(0, 13)),
                    5'($urandom), 6'($urandom), 12'(len)));
      send_bytes(len, 20);
    end else if (r < 85) begin
      if ($urandom_range(0, 3) == 0) send_read(2'($urandom), 12'($urandom));
      else send_read(2'($urandom), 12'($urandom_range(0, 15) * 256 + $urandom_range(0, 7)));
    end else if (r < 92) begin
      it = hdr(1'($urandom), $urandom, $urandom, $urandom, 4'($urandom_range(0, 13)),
               5'($urandom), 6'($urandom_range(0, 32)), 12'($urandom));
      send_item(it);
    end else if (r < 96) begin
      send_bytes($urandom_range(1, 3), 30);
    end else begin
      it = '0;
      it.op = OpNone;
      it.data = 8'($urandom);
      send_item(it);
      sent--;
    end
  endtask

  initial begin
    int wait_cycles;
    for (int k = 0; k < PoolSize; k++) renew_pool(k);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every slot initialised before any read is issued
    for (int s = 0; s < 4; s++) begin
      send_item(hdr(1'b1, 32'(s + 1), 32'hA0 + s, 32'd7, 4'(s), 5'd0, 6'd2, 12'd2));
      send_bytes(2, 0);
    end
    send_item(hdr(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd13, 5'd31,
                  6'd63, 12'd0));
    send_item(hdr(1'b0, 32'd0, 32'd0, 32'd0, 4'd0, 5'd0, 6'd0, 12'd1));
    send_bytes(1, 0);
    // too many fragments, zero count, index past count
    send_item(hdr(1'b1, 32'd9, 32'd9, 32'd9, 4'd1, 5'd0, 6'd33, 12'd1));
    send_item(hdr(1'b1, 32'd9, 32'd9, 32'd9, 4'd1, 5'd0, 6'd0, 12'd1));
    send_item(hdr(1'b1, 32'd9, 32'd9, 32'd9, 4'd1, 5'd5, 6'd3, 12'd1));
    // duplicate, then an empty fragment completing slot 0
    send_item(hdr(1'b1, 32'd2, 32'hA1, 32'd7, 4'd1, 5'd0, 6'd2, 12'd2));
    send_item(hdr(1'b1, 32'd1, 32'hA0, 32'd7, 4'd0, 5'd1, 6'd2, 12'd0));
    // oversized fragment, its bytes arrive as strays
    send_item(hdr(1'b1, 32'd5, 32'd5, 32'd5, 4'd2, 5'd0, 6'd1, 12'd257));
    send_bytes(2, 0);
    send_read(2'd1, 12'd0);
    send_read(2'd1, 12'd1);
    send_read(2'd1, 12'd2);
    send_read(2'd0, 12'd256);
    send_read(2'd3, 12'd4095);
    // interrupted fragment
    send_item(hdr(1'b1, 32'd2, 32'hA1, 32'd7, 4'd1, 5'd1, 6'd2, 12'd3));
    send_bytes(1, 0);
    send_item(hdr(1'b0, 32'd3, 32'd3, 32'd0, 4'd3, 5'd0, 6'd0, 12'd0));
    // a full-size chunk
    send_item(hdr(1'b1, 32'd8, 32'd8, 32'd8, 4'd8, 5'd15, 6'd16, 12'd256));
    send_bytes(256, 10);
    send_read(2'($urandom), 12'd3840);

    while (sent < ItemTarget) random_traffic();
    start <= 1'b0;

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 5000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (20) @(posedge clk_i);

    $display("ran %0d item transfers, %0d results compared", sent, checked);
    $display("covered plain frames, fragment filing, eviction, rejects and reads");
    if (errors == 0 && pending == 0) begin
      $display("PASS fragment_reassembly_table");
    end else begin
      $display("FAIL fragment_reassembly_table");
    end
    $finish;
  end
endmodule

>>> sim.f
design/frt_pkg.sv
design/frt_ram.sv
design/fragment_reassembly_table.sv
verif/frt_checker.sv
verif/tb_fragment_reassembly_table.sv
